### rtl/block_diff_energy_stats_macros.svh
// ----------------------------------------------------------------------------
// Block difference energy statistics: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_DIFF_ENERGY_STATS_MACROS_SVH
`define BLOCK_DIFF_ENERGY_STATS_MACROS_SVH

`ifndef ASSERT_OFF

// Property holds in every cycle outside reset.
`define BDES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle requires the consequent in the next cycle.
`define BDES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BDES_ASSERT(label, prop, msg)
`define BDES_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/bdes_pkg.sv
// ----------------------------------------------------------------------------
// Block difference energy statistics: package
// Fixed widths, block geometry constants and the structs shared by modules.
// ----------------------------------------------------------------------------
package bdes_pkg;

    // Block geometry: the line store always holds the largest row.
    localparam int MAX_BLOCK = 8;
    localparam int COUNT_W   = $clog2(MAX_BLOCK);

    // Last column / row index for each block size.
    localparam logic [COUNT_W-1:0] LAST_IDX_LARGE = COUNT_W'(MAX_BLOCK - 1);
    localparam logic [COUNT_W-1:0] LAST_IDX_SMALL = COUNT_W'(MAX_BLOCK / 2 - 1);

    // Accumulator and result widths.
    localparam int VAR_ACC_W = 27;
    localparam int VAR_OUT_W = 26;
    localparam int GRAD_W    = 29;

    // One finished block result.
    typedef struct packed {
        logic [VAR_OUT_W-1:0] variance;
        logic [GRAD_W-1:0]    gradient_energy;
    } result_t;

    // Status of the accumulation stage, seen by the top level.
    typedef struct packed {
        logic               fire;
        logic               blk_end;
        logic               large_block;
        logic [COUNT_W-1:0] col;
        logic [COUNT_W-1:0] row;
    } status_t;

endpackage

### rtl/bdes_input_stage.sv
// ----------------------------------------------------------------------------
// Block difference energy statistics: input stage
// Registers each accepted sample pair as its signed difference.
// ----------------------------------------------------------------------------
module bdes_input_stage #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [SAMPLE_BITS-1:0]       src_sample,
    input  logic [SAMPLE_BITS-1:0]       ref_sample,
    input  logic                         advance,
    output logic                         item_valid,
    output logic signed [SAMPLE_BITS:0]  item_diff
);

    logic                        item_valid_reg;
    logic                        item_valid_next;
    logic signed [SAMPLE_BITS:0] diff_reg;
    logic                        accept;

    // The stage frees up in the same cycle its item moves on.
    assign in_stall = item_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            diff_reg <= $signed({1'b0, src_sample}) - $signed({1'b0, ref_sample});
        end
    end

    assign item_valid = item_valid_reg;
    assign item_diff  = diff_reg;

endmodule

### rtl/bdes_accum.sv
// ----------------------------------------------------------------------------
// Block difference energy statistics: accumulation stage
// Tracks block position, keeps the row line store and sums the energies.
// ----------------------------------------------------------------------------
module bdes_accum #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         item_valid,
    input  logic signed [SAMPLE_BITS:0]  item_diff,
    input  logic                         out_free,
    output logic                         advance,
    output logic                         result_load,
    output bdes_pkg::result_t            result,
    output bdes_pkg::status_t            status
);

    localparam int DW = SAMPLE_BITS + 1;   // difference width
    localparam int GW = SAMPLE_BITS + 2;   // gradient width

    logic                                 large_block_reg;
    logic [bdes_pkg::COUNT_W-1:0]         col_reg;
    logic [bdes_pkg::COUNT_W-1:0]         col_next;
    logic [bdes_pkg::COUNT_W-1:0]         row_reg;
    logic [bdes_pkg::COUNT_W-1:0]         row_next;
    logic signed [DW-1:0]                 left_reg;
    logic signed [DW-1:0]                 left_next;
    logic [bdes_pkg::VAR_ACC_W-1:0]       var_acc_reg;
    logic [bdes_pkg::VAR_ACC_W-1:0]       var_acc_next;
    logic [bdes_pkg::GRAD_W-1:0]          grad_acc_reg;
    logic [bdes_pkg::GRAD_W-1:0]          grad_acc_next;
    logic signed [DW-1:0]                 line_store [bdes_pkg::MAX_BLOCK];

    logic [bdes_pkg::COUNT_W-1:0]         last_idx;
    logic                                 last_col;
    logic                                 last_row;
    logic                                 blk_end;
    logic signed [DW-1:0]                 above;
    logic signed [GW-1:0]                 h_grad;
    logic signed [GW-1:0]                 v_grad;
    logic [DW-1:0]                        d_mag;
    logic [GW-1:0]                        h_mag;
    logic [GW-1:0]                        v_mag;
    logic [2*DW-1:0]                      d_sq;
    logic [2*GW-1:0]                      h_sq;
    logic [2*GW-1:0]                      v_sq;
    logic [bdes_pkg::GRAD_W-1:0]          h_term;
    logic [bdes_pkg::GRAD_W-1:0]          v_term;
    logic [bdes_pkg::VAR_ACC_W-1:0]       var_sum;
    logic [bdes_pkg::GRAD_W-1:0]          grad_sum;

    assign last_idx = large_block_reg ? bdes_pkg::LAST_IDX_LARGE : bdes_pkg::LAST_IDX_SMALL;
    assign last_col = col_reg >= last_idx;
    assign last_row = row_reg >= last_idx;
    assign blk_end  = last_col && last_row;

    // A block-ending item waits until the result register can take the sums.
    assign advance = item_valid && (!blk_end || out_free);

    assign above  = line_store[col_reg];
    assign h_grad = GW'(item_diff) - GW'(left_reg);
    assign v_grad = GW'(item_diff) - GW'(above);

    assign d_mag = item_diff[DW-1] ? DW'(-item_diff) : DW'(item_diff);
    assign h_mag = h_grad[GW-1] ? GW'(-h_grad) : GW'(h_grad);
    assign v_mag = v_grad[GW-1] ? GW'(-v_grad) : GW'(v_grad);

    assign d_sq = d_mag * d_mag;
    assign h_sq = h_mag * h_mag;
    assign v_sq = v_mag * v_mag;

    // No left neighbor in the first column, no upper neighbor in the first row.
    assign h_term = (col_reg != '0) ? bdes_pkg::GRAD_W'(h_sq) : '0;
    assign v_term = (row_reg != '0) ? bdes_pkg::GRAD_W'(v_sq) : '0;

    assign var_sum  = var_acc_reg + bdes_pkg::VAR_ACC_W'(d_sq);
    assign grad_sum = grad_acc_reg + h_term + v_term;

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        left_next     = left_reg;
        var_acc_next  = var_acc_reg;
        grad_acc_next = grad_acc_reg;
        priority if (cfg_we)
        begin
            // A size change abandons the partial block.
            col_next      = '0;
            row_next      = '0;
            left_next     = '0;
            var_acc_next  = '0;
            grad_acc_next = '0;
        end
        else if (advance)
        begin
            if (!last_col)
            begin
                col_next      = col_reg + 1'b1;
                left_next     = item_diff;
                var_acc_next  = var_sum;
                grad_acc_next = grad_sum;
            end
            else if (!last_row)
            begin
                col_next      = '0;
                row_next      = row_reg + 1'b1;
                left_next     = '0;
                var_acc_next  = var_sum;
                grad_acc_next = grad_sum;
            end
            else
            begin
                col_next      = '0;
                row_next      = '0;
                left_next     = '0;
                var_acc_next  = '0;
                grad_acc_next = '0;
            end
        end
        else
        begin
            // Nothing moves this cycle; the position and sums hold.
            col_next      = col_reg;
            row_next      = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            large_block_reg <= 1'b1;
            col_reg         <= '0;
            row_reg         <= '0;
            left_reg        <= '0;
            var_acc_reg     <= '0;
            grad_acc_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                large_block_reg <= cfg_wdata;
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            left_reg     <= left_next;
            var_acc_reg  <= var_acc_next;
            grad_acc_reg <= grad_acc_next;
        end
    end

    // Line store entries are always written before they are read in a block.
    always_ff @(posedge clk)
    begin
        if (advance && !cfg_we)
        begin
            line_store[col_reg] <= item_diff;
        end
    end

    assign result_load              = advance && blk_end && !cfg_we;
    assign result.variance          = var_sum[bdes_pkg::VAR_OUT_W-1:0];
    assign result.gradient_energy   = grad_sum;

    assign status.fire        = advance;
    assign status.blk_end     = blk_end;
    assign status.large_block = large_block_reg;
    assign status.col         = col_reg;
    assign status.row         = row_reg;

endmodule

### rtl/bdes_output_stage.sv
// ----------------------------------------------------------------------------
// Block difference energy statistics: output stage
// Holds one finished block result until the consumer takes it.
// ----------------------------------------------------------------------------
module bdes_output_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                result_load,
    input  bdes_pkg::result_t                   result,
    output logic                                out_free,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bdes_pkg::VAR_OUT_W-1:0]      variance,
    output logic [bdes_pkg::GRAD_W-1:0]         gradient_energy
);

    logic              out_valid_reg;
    logic              out_valid_next;
    bdes_pkg::result_t result_reg;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign variance        = result_reg.variance;
    assign gradient_energy = result_reg.gradient_energy;

endmodule

### rtl/block_diff_energy_stats.sv
// ----------------------------------------------------------------------------
// Block difference energy statistics: top level
// Sums squared source/reference differences and squared gradients of the
// difference field over 8x8 or 4x4 blocks streamed in raster order.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   ----------------------------------
//   input     in_valid/in_stall    src_sample, ref_sample
//   output    out_valid/out_stall  variance, gradient_energy
//   config    cfg_we               cfg_wdata (large_block)
//
// One sample pair is taken every clock cycle while in_stall is low. A pair
// is registered as its difference in the input register; the squarers and
// accumulators then fold it into the block sums, and the sums of a finished
// block are registered in the output register once it is free.
// Reset selects the 8x8 block size and clears the position counters and sums.
// A stalled result stalls input only when the block-ending pair needs the
// result register; every other pair keeps flowing.
//
module block_diff_energy_stats #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [SAMPLE_BITS-1:0]              src_sample,
    input  logic [SAMPLE_BITS-1:0]              ref_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bdes_pkg::VAR_OUT_W-1:0]      variance,
    output logic [bdes_pkg::GRAD_W-1:0]         gradient_energy
);

`include "block_diff_energy_stats_macros.svh"

    logic                        item_valid;
    logic signed [SAMPLE_BITS:0] item_diff;
    logic                        advance;
    logic                        out_free;
    logic                        result_load;
    bdes_pkg::result_t           result;
    bdes_pkg::status_t           status;

    // Input register: holds the difference of the newest pair.
    bdes_input_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .src_sample (src_sample),
        .ref_sample (ref_sample),
        .advance    (advance),
        .item_valid (item_valid),
        .item_diff  (item_diff)
    );

    // Accumulation: position tracking, line store, squares and running sums.
    bdes_accum #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_valid  (item_valid),
        .item_diff   (item_diff),
        .out_free    (out_free),
        .advance     (advance),
        .result_load (result_load),
        .result      (result),
        .status      (status)
    );

    // Result register: parts the accumulator from a slow consumer.
    bdes_output_stage u_output (
        .clk             (clk),
        .rst_n           (rst_n),
        .result_load     (result_load),
        .result          (result),
        .out_free        (out_free),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .variance        (variance),
        .gradient_energy (gradient_energy)
    );

    // Input backs up only behind a pair that is still waiting in the stage.
    `BDES_ASSERT(a_stall_needs_item, !in_stall || item_valid,
                 "input stalled with empty stage")

    // A finished block always lands in the result register.
    `BDES_ASSERT_NEXT(a_block_end_result, status.fire && status.blk_end && !cfg_we,
                      out_valid, "block end without result")

    // A new result never appears without a block ending in the cycle before.
    `BDES_ASSERT(a_result_source, !$rose(out_valid) || $past(result_load),
                 "result without block end")

    // In the small block size the position never leaves the 4x4 range.
    `BDES_ASSERT(a_small_range,
                 status.large_block || (status.col <= bdes_pkg::LAST_IDX_SMALL
                                        && status.row <= bdes_pkg::LAST_IDX_SMALL),
                 "position outside small block")

endmodule
